### sv/mi3_pkg.sv
`default_nettype none
package mi3_pkg;

  localparam int ELEM_W = 32;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int CMAG_W = PROD_W;
  localparam int DET_W  = COF_W + ELEM_W;
  localparam int DMAG_W = DET_W - 1;
  localparam int REM_W  = DMAG_W + 1;
  localparam int N_ELEM = 9;

  localparam int FRONT_STAGES = 7;
  localparam int DIV_STEPS    = ELEM_W;
  localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + 2;

  localparam logic [ELEM_W-1:0] POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] NEG_MAX = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a13;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
    logic signed [ELEM_W-1:0] a23;
    logic signed [ELEM_W-1:0] a31;
    logic signed [ELEM_W-1:0] a32;
    logic signed [ELEM_W-1:0] a33;
  } mat_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] inv11;
    logic signed [ELEM_W-1:0] inv12;
    logic signed [ELEM_W-1:0] inv13;
    logic signed [ELEM_W-1:0] inv21;
    logic signed [ELEM_W-1:0] inv22;
    logic signed [ELEM_W-1:0] inv23;
    logic signed [ELEM_W-1:0] inv31;
    logic signed [ELEM_W-1:0] inv32;
    logic signed [ELEM_W-1:0] inv33;
    logic                     singular;
    logic                     saturated;
  } inv_out_t;

  // magnitudes and signs handed from the cofactor front end to the divider
  typedef struct packed {
    logic                               valid;
    logic                               singular;
    logic [DMAG_W-1:0]                  dmag;
    logic [N_ELEM-1:0]                  neg;
    logic [N_ELEM-1:0][CMAG_W-1:0]      cmag;
  } quot_req_t;

endpackage
`default_nettype wire

### sv/mi3_front.sv
`default_nettype none
module mi3_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire mi3_pkg::mat_in_t mat,
  output mi3_pkg::quot_req_t   req
);
  import mi3_pkg::*;

  logic v1, v2, v3, v4, v5, v6, v7;
  mat_in_t m1;
  logic signed [N_ELEM-1:0][1:0][PROD_W-1:0] p2;
  logic signed [2:0][ELEM_W-1:0] row2, row3;
  logic signed [N_ELEM-1:0][COF_W-1:0] cof3, cof4, cof5, cof6;
  logic signed [2:0][COF_W-1:0] plo4, phi4;
  logic [2:0][DET_W-1:0] term5;
  logic [DET_W-1:0] det6;
  logic [N_ELEM-1:0][CMAG_W-1:0] cmag7;
  logic [N_ELEM-1:0] neg7;
  logic [DMAG_W-1:0] dmag7;
  logic sing7;
  logic [DET_W-1:0] det_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    m1 <= mat;
    // element products for the nine cofactors
    p2[0][0] <= m1.a22 * m1.a33;  p2[0][1] <= m1.a23 * m1.a32;
    p2[1][0] <= m1.a13 * m1.a32;  p2[1][1] <= m1.a12 * m1.a33;
    p2[2][0] <= m1.a12 * m1.a23;  p2[2][1] <= m1.a13 * m1.a22;
    p2[3][0] <= m1.a23 * m1.a31;  p2[3][1] <= m1.a21 * m1.a33;
    p2[4][0] <= m1.a11 * m1.a33;  p2[4][1] <= m1.a13 * m1.a31;
    p2[5][0] <= m1.a13 * m1.a21;  p2[5][1] <= m1.a11 * m1.a23;
    p2[6][0] <= m1.a21 * m1.a32;  p2[6][1] <= m1.a22 * m1.a31;
    p2[7][0] <= m1.a12 * m1.a31;  p2[7][1] <= m1.a11 * m1.a32;
    p2[8][0] <= m1.a11 * m1.a22;  p2[8][1] <= m1.a12 * m1.a21;
    row2[0] <= m1.a11; row2[1] <= m1.a12; row2[2] <= m1.a13;
    row3 <= row2;
    for (int i = 0; i < N_ELEM; i++) begin
      cof3[i] <= {p2[i][0][PROD_W-1], p2[i][0]} - {p2[i][1][PROD_W-1], p2[i][1]};
    end
    cof4 <= cof3;
    // determinant along row 1, each 65x32 product split in two halves
    for (int k = 0; k < 3; k++) begin
      plo4[k] <= $signed({1'b0, cof3[3*k][ELEM_W-1:0]}) * $signed(row3[k]);
      phi4[k] <= $signed(cof3[3*k][COF_W-1:ELEM_W]) * $signed(row3[k]);
    end
    cof5 <= cof4;
    for (int k = 0; k < 3; k++) begin
      term5[k] <= {phi4[k], {ELEM_W{1'b0}}} + {{ELEM_W{plo4[k][COF_W-1]}}, plo4[k]};
    end
    cof6 <= cof5;
    det6 <= term5[0] + term5[1] + term5[2];
    sing7 <= (det6 == '0);
    dmag7 <= det_abs[DMAG_W-1:0];
    for (int i = 0; i < N_ELEM; i++) begin
      neg7[i]  <= cof6[i][COF_W-1] ^ det6[DET_W-1];
      cmag7[i] <= cof6[i][COF_W-1] ? CMAG_W'(-cof6[i]) : CMAG_W'(cof6[i]);
    end
  end

  assign det_abs = det6[DET_W-1] ? -det6 : det6;

  assign req.valid    = v7;
  assign req.singular = sing7;
  assign req.dmag     = dmag7;
  assign req.neg      = neg7;
  assign req.cmag     = cmag7;

endmodule
`default_nettype wire

### sv/mi3_divider.sv
`default_nettype none
module mi3_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mi3_pkg::quot_req_t req,
  output logic                    done,
  output mi3_pkg::inv_out_t       result
);
  import mi3_pkg::*;

  typedef struct packed {
    logic [DMAG_W-1:0] r;
    logic [ELEM_W-1:0] q;
    logic              ovf;
    logic              neg;
  } lane_t;

  logic                 sv [0:DIV_STEPS];
  logic                 ssing [0:DIV_STEPS];
  logic [DMAG_W-1:0]    sd [0:DIV_STEPS];
  lane_t [N_ELEM-1:0]   sl [0:DIV_STEPS];

  // first stage: quotient overflows 32 bits when |cof| >= |det|
  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else sv[0] <= req.valid;
    ssing[0] <= req.singular;
    sd[0]    <= req.dmag;
    for (int i = 0; i < N_ELEM; i++) begin
      sl[0][i].r   <= DMAG_W'(req.cmag[i]);
      sl[0][i].q   <= '0;
      sl[0][i].ovf <= (DMAG_W'(req.cmag[i]) >= req.dmag);
      sl[0][i].neg <= req.neg[i];
    end
  end

  // one restoring step per stage, all lanes in step
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    logic [N_ELEM-1:0][REM_W-1:0] r2;
    logic [N_ELEM-1:0]            fit;
    always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
        r2[i]  = {sl[j-1][i].r, 1'b0};
        fit[i] = (r2[i] >= {1'b0, sd[j-1]});
      end
    end
    always_ff @(posedge clk) begin
      if (rst) sv[j] <= 1'b0;
      else sv[j] <= sv[j-1];
      ssing[j] <= ssing[j-1];
      sd[j]    <= sd[j-1];
      for (int i = 0; i < N_ELEM; i++) begin
        sl[j][i].r   <= fit[i] ? DMAG_W'(r2[i] - {1'b0, sd[j-1]}) : DMAG_W'(r2[i]);
        sl[j][i].q   <= {sl[j-1][i].q[ELEM_W-2:0], fit[i]};
        sl[j][i].ovf <= sl[j-1][i].ovf;
        sl[j][i].neg <= sl[j-1][i].neg;
      end
    end
  end

  logic [N_ELEM-1:0][ELEM_W-1:0] val;
  logic [N_ELEM-1:0]             clip;

  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      if (sl[DIV_STEPS][i].neg) begin
        clip[i] = sl[DIV_STEPS][i].ovf || (sl[DIV_STEPS][i].q > NEG_MAX);
        val[i]  = clip[i] ? NEG_MAX : -sl[DIV_STEPS][i].q;
      end else begin
        clip[i] = sl[DIV_STEPS][i].ovf || (sl[DIV_STEPS][i].q > POS_MAX);
        val[i]  = clip[i] ? POS_MAX : sl[DIV_STEPS][i].q;
      end
      if (ssing[DIV_STEPS]) begin
        clip[i] = 1'b0;
        val[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= sv[DIV_STEPS];
    result.inv11     <= val[0];
    result.inv12     <= val[1];
    result.inv13     <= val[2];
    result.inv21     <= val[3];
    result.inv22     <= val[4];
    result.inv23     <= val[5];
    result.inv31     <= val[6];
    result.inv32     <= val[7];
    result.inv33     <= val[8];
    result.singular  <= ssing[DIV_STEPS];
    result.saturated <= |clip;
  end

endmodule
`default_nettype wire

### sv/matrix3_inverse_core.sv
`default_nettype none
// 3x3 inverse in signed Q16.16: each element is cofactor * 2^32 / det, truncated
// toward zero and clipped to 32 bits; a zero determinant gives all zeros and
// singular. Fully pipelined: busy is always low, a matrix may be started every
// cycle, and its result appears on result with done high after start is taken,
// passing through 7 stages of products and determinant, one overflow compare
// stage, 32 restoring divide steps in nine parallel lanes and one output
// register. The result is shown for one cycle only; the receiver must take it.
module matrix3_inverse_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire mi3_pkg::mat_in_t  mat,
  output logic                   done,
  output mi3_pkg::inv_out_t      result
);
  import mi3_pkg::*;

  quot_req_t req;

  assign busy = 1'b0;

  mi3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .mat      (mat),
    .req      (req)
  );

  mi3_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .done   (done),
    .result (result)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done) else $error("item lost in pipeline");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.singular) |-> (result.inv11 == 0 && result.inv22 == 0 &&
      result.inv33 == 0 && !result.saturated)) else $error("singular result not cleared");

  a_div_in: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> ##(DIV_STEPS + 2) done) else $error("divider dropped item");

endmodule
`default_nettype wire
